/* sv/at2d_pkg.sv */
package at2d_pkg;

	// Fixed-point format of the coefficients and of the point coordinates.
	localparam int FRAC_BITS   = 16;
	localparam int COEFF_WIDTH = 32;
	localparam int POINT_WIDTH = 32;

	// Multiplier operand widths. Operand A must hold a negated point coordinate.
	localparam int OPA_W  = (COEFF_WIDTH > POINT_WIDTH) ? COEFF_WIDTH : POINT_WIDTH + 1;
	localparam int OPB_W  = (COEFF_WIDTH > POINT_WIDTH) ? COEFF_WIDTH : POINT_WIDTH;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int RND_W  = PROD_W - FRAC_BITS;
	localparam int SUM_W  = RND_W + 2;

	typedef logic signed [COEFF_WIDTH-1:0] coeff_t;
	typedef logic signed [POINT_WIDTH-1:0] point_t;
	typedef logic signed [OPA_W-1:0]       opa_t;
	typedef logic signed [OPB_W-1:0]       opb_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [RND_W-1:0]       rnd_t;
	typedef logic signed [SUM_W-1:0]       sum_t;

	// Fixed-point one and half an LSB of the rounded product.
	localparam coeff_t ONE      = coeff_t'(1) << FRAC_BITS;
	localparam prod_t  HALF_LSB = prod_t'(1) << (FRAC_BITS - 1);

	typedef enum logic [2:0] {
		OP_IDENTITY  = 3'd0,
		OP_TRANSLATE = 3'd1,
		OP_ROTATE    = 3'd2,
		OP_SCALE     = 3'd3,
		OP_REFLECT   = 3'd4,
		OP_POINT     = 3'd5
	} opcode_t;

	typedef struct packed {
		logic   hit;
		coeff_t val;
	} coeff_sat_t;

	typedef struct packed {
		logic   hit;
		point_t val;
	} point_sat_t;

	// Clip a sum to the coefficient range and report whether it clipped.
	function automatic coeff_sat_t sat_coeff(input sum_t v);
		coeff_sat_t                  r;
		logic [SUM_W-COEFF_WIDTH:0]  top;
		top   = v[SUM_W-1:COEFF_WIDTH-1];
		r.hit = !((&top) || !(|top));
		if (r.hit) begin
			r.val = v[SUM_W-1] ? {1'b1, {(COEFF_WIDTH-1){1'b0}}}
			                   : {1'b0, {(COEFF_WIDTH-1){1'b1}}};
		end else begin
			r.val = v[COEFF_WIDTH-1:0];
		end
		return r;
	endfunction

	// Clip a sum to the point range and report whether it clipped.
	function automatic point_sat_t sat_point(input sum_t v);
		point_sat_t                  r;
		logic [SUM_W-POINT_WIDTH:0]  top;
		top   = v[SUM_W-1:POINT_WIDTH-1];
		r.hit = !((&top) || !(|top));
		if (r.hit) begin
			r.val = v[SUM_W-1] ? {1'b1, {(POINT_WIDTH-1){1'b0}}}
			                   : {1'b0, {(POINT_WIDTH-1){1'b1}}};
		end else begin
			r.val = v[POINT_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

/* sv/affine_2d_transform_engine_top.sv */
// 2D affine transform engine. The block holds a 2x3 Q16.16 matrix (bottom row
// implied 0 0 1) and takes one command item per cycle: load identity, or
// premultiply the matrix by a translate, rotate, scale or reflect, or map a
// point. Only the point command returns a result item, and the saturated output
// is the sticky overflow flag including any clipping by that point. A command is
// registered at the edge that accepts it, then six parallel lanes of two
// multipliers each form the new matrix or the point from that input register. A
// point's result item is then registered in the output register and offered
// from there, and the sustained rate is one item per clock. The loop through the
// matrix register is one multiply, a three-term add and a clip. The input side
// stalls only when a point waits in the input register behind an unread result.
module affine_2d_transform_engine_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  logic [2:0]       opcode,
	input  at2d_pkg::point_t arg_x,
	input  at2d_pkg::point_t arg_y,
	input  logic             dir,
	output logic             res_valid,
	input  logic             res_stall,
	output at2d_pkg::point_t out_x,
	output at2d_pkg::point_t out_y,
	output logic             saturated
);
	import at2d_pkg::*;

	localparam int NUM_COEFF = 6;

	// Input register.
	logic    vld_s1;
	opcode_t op_s1;
	point_t  x_s1;
	point_t  y_s1;
	logic    dir_s1;

	// Matrix state and output register.
	coeff_t  m_q [NUM_COEFF];
	logic    sticky_q;
	logic    res_valid_q;
	point_t  out_x_q;
	point_t  out_y_q;
	logic    saturated_q;

	logic    is_point;
	logic    go_s1;
	logic    fire_point;
	logic    any_coeff_hit;

	opa_t       r_mat [NUM_COEFF];
	opa_t       la0   [NUM_COEFF];
	opb_t       lb0   [NUM_COEFF];
	opa_t       la1   [NUM_COEFF];
	opb_t       lb1   [NUM_COEFF];
	opb_t       lt2   [NUM_COEFF];
	sum_t       lsum  [NUM_COEFF];
	coeff_sat_t csat  [NUM_COEFF];
	point_sat_t px_sat;
	point_sat_t py_sat;

	// A point item needs the output register free; other items always move on.
	assign is_point   = (op_s1 == OP_POINT);
	assign go_s1      = !is_point || !res_valid_q || !res_stall;
	assign fire_point = vld_s1 && is_point && go_s1;
	assign cmd_stall  = vld_s1 && !go_s1;

	// Capture the incoming item whenever the input register is free to move.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			vld_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			op_s1  <= opcode_t'(opcode);
			x_s1   <= arg_x;
			y_s1   <= arg_y;
			dir_s1 <= dir;
		end
	end

	// Left-hand matrix R of the current command, row major, top two rows.
	always_comb begin
		opa_t one_a;
		opa_t x_a;
		opa_t y_a;
		one_a = opa_t'(ONE);
		x_a   = opa_t'(x_s1);
		y_a   = opa_t'(y_s1);
		for (int k = 0; k < NUM_COEFF; k++) begin
			r_mat[k] = '0;
		end
		case (op_s1)
			OP_TRANSLATE: begin
				r_mat[0] = one_a;
				r_mat[2] = x_a;
				r_mat[4] = one_a;
				r_mat[5] = y_a;
			end
			OP_ROTATE: begin
				r_mat[0] = x_a;
				r_mat[4] = x_a;
				r_mat[1] = dir_s1 ? y_a : -y_a;
				r_mat[3] = dir_s1 ? -y_a : y_a;
			end
			OP_SCALE: begin
				r_mat[0] = x_a;
				r_mat[4] = y_a;
			end
			OP_REFLECT: begin
				if (!dir_s1) begin
					r_mat[0] = -one_a;
					r_mat[4] = one_a;
					r_mat[2] = x_a;
				end else begin
					r_mat[0] = one_a;
					r_mat[4] = -one_a;
					r_mat[5] = y_a;
				end
			end
			default: begin
			end
		endcase
	end

	// Lane operands. Lane (i, j) forms new coefficient m[i][j]; for a point
	// item the lanes of column zero form the two output coordinates instead.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			for (int j = 0; j < 3; j++) begin
				la0[i*3+j] = r_mat[i*3];
				lb0[i*3+j] = opb_t'(m_q[j]);
				la1[i*3+j] = r_mat[i*3+1];
				lb1[i*3+j] = opb_t'(m_q[3+j]);
				lt2[i*3+j] = (j == 2) ? opb_t'(r_mat[i*3+2]) : '0;
			end
		end
		if (is_point) begin
			for (int i = 0; i < 2; i++) begin
				la0[i*3] = opa_t'(m_q[i*3]);
				lb0[i*3] = opb_t'(x_s1);
				la1[i*3] = opa_t'(m_q[i*3+1]);
				lb1[i*3] = opb_t'(y_s1);
				lt2[i*3] = opb_t'(m_q[i*3+2]);
			end
		end
	end

	for (genvar g = 0; g < NUM_COEFF; g++) begin : g_lane
		at2d_lane u_lane (
			.a0  (la0[g]),
			.b0  (lb0[g]),
			.a1  (la1[g]),
			.b1  (lb1[g]),
			.t2  (lt2[g]),
			.sum (lsum[g])
		);
	end

	// Clip the lane sums to the coefficient range and to the point range.
	always_comb begin
		any_coeff_hit = 1'b0;
		for (int k = 0; k < NUM_COEFF; k++) begin
			csat[k]       = sat_coeff(lsum[k]);
			any_coeff_hit = any_coeff_hit | csat[k].hit;
		end
		px_sat = sat_point(lsum[0]);
		py_sat = sat_point(lsum[3]);
	end

	// Matrix and sticky overflow update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_COEFF; k++) begin
				m_q[k] <= (k == 0 || k == 4) ? ONE : coeff_t'(0);
			end
			sticky_q <= 1'b0;
		end else if (vld_s1 && go_s1) begin
			case (op_s1)
				OP_IDENTITY: begin
					for (int k = 0; k < NUM_COEFF; k++) begin
						m_q[k] <= (k == 0 || k == 4) ? ONE : coeff_t'(0);
					end
					sticky_q <= 1'b0;
				end
				OP_TRANSLATE, OP_ROTATE, OP_SCALE, OP_REFLECT: begin
					for (int k = 0; k < NUM_COEFF; k++) begin
						m_q[k] <= csat[k].val;
					end
					sticky_q <= sticky_q | any_coeff_hit;
				end
				OP_POINT: begin
					sticky_q <= sticky_q | px_sat.hit | py_sat.hit;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register for point results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (res_valid_q && res_stall) || fire_point;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_point) begin
			out_x_q     <= px_sat.val;
			out_y_q     <= py_sat.val;
			saturated_q <= sticky_q | px_sat.hit | py_sat.hit;
		end
	end

	assign res_valid = res_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign saturated = saturated_q;

endmodule

/* sv/at2d_lane.sv */
module at2d_lane (
	input  at2d_pkg::opa_t a0,
	input  at2d_pkg::opb_t b0,
	input  at2d_pkg::opa_t a1,
	input  at2d_pkg::opb_t b1,
	input  at2d_pkg::opb_t t2,
	output at2d_pkg::sum_t sum
);
	import at2d_pkg::*;

	prod_t p0;
	prod_t p1;
	prod_t p0_half;
	prod_t p1_half;
	rnd_t  rp0;
	rnd_t  rp1;

	// Two full products, each rounded half up to the fraction width.
	assign p0      = prod_t'(a0) * prod_t'(b0);
	assign p1      = prod_t'(a1) * prod_t'(b1);
	assign p0_half = p0 + HALF_LSB;
	assign p1_half = p1 + HALF_LSB;
	assign rp0     = p0_half[PROD_W-1:FRAC_BITS];
	assign rp1     = p1_half[PROD_W-1:FRAC_BITS];

	// Exact sum of the rounded products and the term that needs no multiply.
	assign sum = sum_t'(rp0) + sum_t'(rp1) + sum_t'(t2);

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import at2d_pkg::*;

	// Opcodes outside the command set; the block must ignore them.
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	localparam int RANDOM_ITEMS = 1750;
	localparam int IDLE_LIMIT   = 1000;
	localparam int TAIL_CYCLES  = 10;

	typedef logic signed [127:0] acc_t;

	typedef struct {
		logic [2:0] op;
		point_t     ax;
		point_t     ay;
		logic       dir_bit;
		int         gap_after;
		bit         drain;
	} cmd_item_t;

	typedef struct {
		point_t px;
		point_t py;
		logic   sat;
	} mapped_point_t;

	logic   clk       = 1'b0;
	logic   arst_n    = 1'b0;
	logic   cmd_valid = 1'b0;
	logic   cmd_stall;
	logic   [2:0] opcode = OP_IDENTITY;
	point_t arg_x     = '0;
	point_t arg_y     = '0;
	logic   dir       = 1'b0;
	logic   res_valid;
	logic   res_stall = 1'b0;
	point_t out_x;
	point_t out_y;
	logic   saturated;

	cmd_item_t     cmd_backlog[$];
	mapped_point_t expected_points[$];

	// Predicted state of the block.
	longint coeffs[6] = '{longint'(ONE), 0, 0, 0, longint'(ONE), 0};
	logic   ovf_sticky = 1'b0;

	int  errors      = 0;
	int  point_count = 0;
	int  rcv_count   = 0;
	int  gap_left    = 0;
	int  stall_left  = 0;
	int  idle_cycles = 0;
	int  mon_cycle   = 0;
	bit  quiet_tx    = 0;

	affine_2d_transform_engine_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.opcode    (opcode),
		.arg_x     (arg_x),
		.arg_y     (arg_y),
		.dir       (dir),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.out_x     (out_x),
		.out_y     (out_y),
		.saturated (saturated)
	);

	always #10 clk = ~clk;

	// Product of two fixed-point values, rounded half up to the fraction width.
	function automatic acc_t round_mul(input longint a, input longint b);
		acc_t p;
		p = acc_t'(a) * acc_t'(b);
		p = p + (acc_t'(1) <<< (FRAC_BITS - 1));
		return p >>> FRAC_BITS;
	endfunction

	// Clip a sum to a signed field of w bits; any clip sets the sticky flag.
	function automatic longint clip_sum(input acc_t v, input int w);
		acc_t top;
		top = (acc_t'(1) <<< (w - 1)) - 1;
		if (v > top) begin
			ovf_sticky = 1'b1;
			return longint'(top);
		end
		if (v < -top - 1) begin
			ovf_sticky = 1'b1;
			return longint'(-top - 1);
		end
		return longint'(v);
	endfunction

	function automatic longint dot3(input longint a0, input longint a1, input longint a2,
	                                input longint b0, input longint b1, input longint b2,
	                                input int w);
		return clip_sum(round_mul(a0, b0) + round_mul(a1, b1) + round_mul(a2, b2), w);
	endfunction

	// Advance the predicted matrix by one command; a point queues its mapped result.
	task automatic apply_command(input logic [2:0] op, input point_t x, input point_t y,
	                             input logic d);
		longint        r[6];
		longint        nm[6];
		longint        one;
		longint        xl;
		longint        yl;
		bit            touch;
		mapped_point_t res;
		r = '{default: 0};
		one = longint'(ONE);
		xl = x;
		yl = y;
		touch = 1'b1;
		case (op)
			OP_IDENTITY: begin
				coeffs = '{one, 0, 0, 0, one, 0};
				ovf_sticky = 1'b0;
				touch = 1'b0;
			end
			OP_TRANSLATE: begin
				r[0] = one; r[2] = xl; r[4] = one; r[5] = yl;
			end
			OP_ROTATE: begin
				r[0] = xl; r[4] = xl;
				r[1] = d ? yl : -yl;
				r[3] = d ? -yl : yl;
			end
			OP_SCALE: begin
				r[0] = xl; r[4] = yl;
			end
			OP_REFLECT: begin
				if (!d) begin
					r[0] = -one; r[4] = one; r[2] = xl;
				end else begin
					r[0] = one; r[4] = -one; r[5] = yl;
				end
			end
			OP_POINT: begin
				res.px = point_t'(dot3(coeffs[0], coeffs[1], coeffs[2], xl, yl, one,
				                       POINT_WIDTH));
				res.py = point_t'(dot3(coeffs[3], coeffs[4], coeffs[5], xl, yl, one,
				                       POINT_WIDTH));
				res.sat = ovf_sticky;
				expected_points.push_back(res);
				point_count++;
				touch = 1'b0;
			end
			default: touch = 1'b0;
		endcase
		// New matrix is R times the current one; the implied bottom row is 0 0 1.
		if (touch) begin
			for (int i = 0; i < 2; i++)
				for (int j = 0; j < 3; j++)
					nm[i*3+j] = dot3(r[i*3], r[i*3+1], r[i*3+2], coeffs[j], coeffs[3+j],
					                 (j == 2) ? one : 0, COEFF_WIDTH);
			coeffs = nm;
		end
	endtask

	// Idle length: mostly none or short, now and then long.
	function automatic int draw_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Uniform fixed-point value in [-span, span].
	function automatic point_t rnd_fix(input int span);
		int v;
		v = $urandom_range(0, 2 * span);
		return point_t'(v - span);
	endfunction

	task automatic push_cmd(input logic [2:0] op, input point_t ax, input point_t ay,
	                        input logic d, input bit drain);
		cmd_item_t it;
		it.op = op;
		it.ax = ax;
		it.ay = ay;
		it.dir_bit = d;
		it.gap_after = quiet_tx ? 0 : draw_len();
		it.drain = drain;
		cmd_backlog.push_back(it);
	endtask

	// Command driver: presents queued items and tracks each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (cmd_valid && !cmd_stall)
				apply_command(opcode, arg_x, arg_y, dir);
			if (!cmd_valid || !cmd_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (cmd_backlog.size() == 0 ||
				             (cmd_backlog[0].drain && point_count != rcv_count)) begin
					cmd_valid <= 1'b0;
				end else begin
					opcode    <= cmd_backlog[0].op;
					arg_x     <= cmd_backlog[0].ax;
					arg_y     <= cmd_backlog[0].ay;
					dir       <= cmd_backlog[0].dir_bit;
					gap_left  = cmd_backlog[0].gap_after;
					cmd_valid <= 1'b1;
					void'(cmd_backlog.pop_front());
				end
			end
		end
	end

	// Result monitor: checks each accepted item and throttles with res_stall.
	always @(posedge clk or negedge arst_n) begin
		mapped_point_t e;
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_points.size() == 0) begin
					$display("%0t: unexpected result item x=%h y=%h sat=%b", $time,
					         out_x, out_y, saturated);
					errors++;
				end else begin
					e = expected_points.pop_front();
					if (out_x !== e.px) begin
						$display("%0t: out_x expected %h actual %h", $time, e.px, out_x);
						errors++;
					end
					if (out_y !== e.py) begin
						$display("%0t: out_y expected %h actual %h", $time, e.py, out_y);
						errors++;
					end
					if (saturated !== e.sat) begin
						$display("%0t: saturated expected %b actual %b", $time, e.sat,
						         saturated);
						errors++;
					end
				end
				rcv_count <= rcv_count + 1;
			end
			// One stretch in four runs without back-pressure.
			mon_cycle++;
			if (stall_left == 0 && ((mon_cycle >> 9) % 4) != 0)
				stall_left = draw_len();
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles in which neither side moves an item.
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL affine_2d_transform_engine_top");
			$finish;
		end
	end

	initial begin
		int         random_count;
		int         n_tf;
		int         n_pt;
		int         sel;
		bit         drain_due;
		logic [2:0] op;
		point_t     ax;
		point_t     ay;

		// Directed part: field extremes, every command, clipping and the flag clear.
		push_cmd(OP_POINT, 32'sh0000_0000, 32'sh0000_0000, 1'b0, 0);
		push_cmd(OP_POINT, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1, 0);
		push_cmd(OP_POINT, 32'sh0001_8000, -32'sh0002_4000, 1'b0, 0);
		push_cmd(OP_TRANSLATE, 32'sh0003_0000, -32'sh0001_0000, 1'b0, 0);
		push_cmd(OP_POINT, 32'sh0001_0000, 32'sh0001_0000, 1'b0, 0);
		push_cmd(OP_ROTATE, 32'sh0000_ddb4, 32'sh0000_8000, 1'b0, 0);
		push_cmd(OP_POINT, 32'sh0002_0000, -32'sh0001_0000, 1'b0, 0);
		push_cmd(OP_ROTATE, 32'sh0000_ddb4, 32'sh0000_8000, 1'b1, 0);
		push_cmd(OP_POINT, 32'sh0002_0000, -32'sh0001_0000, 1'b1, 0);
		push_cmd(OP_SCALE, 32'sh0002_0000, -32'sh0000_8000, 1'b0, 0);
		push_cmd(OP_REFLECT, 32'sh0005_0000, 32'sh7fff_ffff, 1'b0, 0);
		push_cmd(OP_REFLECT, 32'sh8000_0000, -32'sh0003_0000, 1'b1, 0);
		push_cmd(OP_POINT, 32'sh0000_0001, -32'sh0000_0001, 1'b0, 0);
		push_cmd(OP_SPARE_A, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1, 0);
		push_cmd(OP_SPARE_B, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 0);
		push_cmd(OP_POINT, 32'sh0001_0000, 32'sh0000_0000, 1'b0, 0);
		push_cmd(OP_IDENTITY, 32'sh0000_0000, 32'sh0000_0000, 1'b0, 1);
		push_cmd(OP_TRANSLATE, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0, 0);
		push_cmd(OP_POINT, 32'sh0000_0000, 32'sh0000_0000, 1'b0, 0);
		push_cmd(OP_IDENTITY, 32'sh0000_0000, 32'sh0000_0000, 1'b1, 0);
		push_cmd(OP_SCALE, 32'sh0002_0000, 32'sh0002_0000, 1'b0, 0);
		push_cmd(OP_POINT, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0, 0);
		push_cmd(OP_IDENTITY, 32'sh0000_0000, 32'sh0000_0000, 1'b0, 0);
		push_cmd(OP_ROTATE, 32'sh0000_0000, 32'sh8000_0000, 1'b0, 0);
		push_cmd(OP_POINT, 32'sh0000_0001, 32'sh0000_0001, 1'b0, 0);
		push_cmd(OP_SCALE, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1, 0);
		push_cmd(OP_POINT, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1, 0);

		// Random part: mostly whole sequences (identity, transforms, points).
		random_count = 0;
		drain_due = 0;
		while (random_count < RANDOM_ITEMS) begin
			quiet_tx = ((random_count / 150) % 4) == 3;
			if ($urandom_range(0, 99) < 85) begin
				if ($urandom_range(0, 99) < 70) begin
					push_cmd(OP_IDENTITY, point_t'($urandom), point_t'($urandom),
					         1'($urandom), drain_due);
					drain_due = 0;
					random_count++;
				end
				n_tf = $urandom_range(1, 4);
				for (int k = 0; k < n_tf; k++) begin
					sel = $urandom_range(0, 3);
					ax = point_t'($urandom);
					ay = point_t'($urandom);
					case (sel)
						0: begin
							op = OP_TRANSLATE;
							if ($urandom_range(0, 9) != 0) begin
								ax = rnd_fix(1 << 20);
								ay = rnd_fix(1 << 20);
							end
						end
						1: begin
							op = OP_ROTATE;
							ax = rnd_fix(1 << 16);
							ay = rnd_fix(1 << 16);
						end
						2: begin
							op = OP_SCALE;
							if ($urandom_range(0, 9) != 0) begin
								ax = rnd_fix(1 << 18);
								ay = rnd_fix(1 << 18);
							end
						end
						default: begin
							op = OP_REFLECT;
							if ($urandom_range(0, 1) != 0)
								ax = rnd_fix(1 << 20);
							else
								ay = rnd_fix(1 << 20);
						end
					endcase
					push_cmd(op, ax, ay, 1'($urandom), drain_due);
					drain_due = 0;
					random_count++;
				end
				n_pt = $urandom_range(1, 6);
				for (int k = 0; k < n_pt; k++) begin
					if ($urandom_range(0, 9) != 0)
						push_cmd(OP_POINT, rnd_fix(1 << 22), rnd_fix(1 << 22), 1'($urandom), 0);
					else
						push_cmd(OP_POINT, point_t'($urandom), point_t'($urandom),
						         1'($urandom), 0);
					random_count++;
				end
			end else begin
				// Noise: any opcode with unconstrained arguments.
				op = 3'($urandom_range(0, 7));
				push_cmd(op, point_t'($urandom), point_t'($urandom), 1'($urandom), 0);
				if (op != OP_SPARE_A && op != OP_SPARE_B)
					random_count++;
			end
			// Now and then hold the sender until the block has drained.
			if ((random_count % 300) < 4 && random_count > 4)
				drain_due = 1;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the sender to run dry and every mapped point to come back.
		do @(negedge clk);
		while (cmd_backlog.size() != 0 || cmd_valid || rcv_count != point_count);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (errors == 0 && expected_points.size() == 0) begin
			$display("PASS affine_2d_transform_engine_top");
		end else begin
			$display("FAIL affine_2d_transform_engine_top");
		end
		$finish;
	end

endmodule
